// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks sampled on a rising clock edge, off while reset is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// antecedent implies consequent in the next cycle
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

// ----- hw/rtl/rpa_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpa_pkg
// shared codes and field widths of the page allocator
// ---------------------------------------------------------------------------
package rpa_pkg;

    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 1;
    // wide enough for any page number, bound or pool size without overflow
    localparam int WIDE_W      = 33;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_ALLOC  = 2'd0;
    localparam t_cmd CMD_FREE   = 2'd1;
    localparam t_cmd CMD_INCREF = 2'd2;
    localparam t_cmd CMD_INIT   = 2'd3;

    localparam t_status STAT_OK    = 3'd0;
    localparam t_status STAT_EMPTY = 3'd1;
    localparam t_status STAT_BAD   = 3'd2;
    localparam t_status STAT_ZERO  = 3'd3;
    localparam t_status STAT_SAT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_PAGE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PAGE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] LOW_PAGE_RST  = 20'd0;
    localparam logic [CFG_DATA_W-1:0] HIGH_PAGE_RST = 20'd32768;

endpackage

// ----- hw/rtl/rpa_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpa_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/refcounted_page_allocator.sv -----
`timescale 1ns / 1ps
// alloc, free and incref: result strobe registered after the issue and rmw states
//   (issue only if the pool is empty or the address is bad); next word taken in rmw
// initialize: result after a sweep over all count entries, one cleared per cycle
// the count ram's single read/modify/write path sets the pace
// synchronous active-low reset, then a sweep over every entry zeroes the counts
// with busy high; results always go out, the receiver cannot stall
// ---------------------------------------------------------------------------
// refcounted_page_allocator
// lifo free-page stack plus a per-page reference count, each in its own ram
// ---------------------------------------------------------------------------
module refcounted_page_allocator #(
    parameter int NUM_PAGES  = 32768,  // pool capacity in pages
    parameter int PAGE_BYTES = 4096,   // page size, a power of two
    parameter int COUNT_BITS = 8       // width of one reference count
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic [rpa_pkg::CMD_W-1:0]           i_command,
    input  logic [rpa_pkg::ADDR_W-1:0]          i_address,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // result side
    output logic                                o_valid,
    output logic [rpa_pkg::STATUS_W-1:0]        o_status,
    output logic [rpa_pkg::ADDR_W-1:0]          o_page_address,
    output logic                                o_returned_to_pool,
    output logic [rpa_pkg::COUNT_OUT_W-1:0]     o_count_after
);

    localparam int SLOT_W     = $clog2(NUM_PAGES);       // ram index width
    localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);   // holds 0..NUM_PAGES
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WIDE_W     = rpa_pkg::WIDE_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a command
    localparam logic [1:0] ST_ISSUE = 2'd1;  // checks done, ram read issued
    localparam logic [1:0] ST_RMW   = 2'd2;  // read data back, write and report
    localparam logic [1:0] ST_SWEEP = 2'd3;  // clearing counts, filling stack

    // control state
    logic [1:0]                      r_state, n_state;
    logic [DEPTH_W-1:0]              r_depth, n_depth;
    logic [DEPTH_W-1:0]              r_sweep, n_sweep;
    logic                            r_sweep_init, n_sweep_init;
    logic [rpa_pkg::CFG_DATA_W-1:0]  r_low, r_high;
    logic                            r_valid, n_valid;

    // command payload
    logic [rpa_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [rpa_pkg::ADDR_W-1:0]      r_address, n_address;
    logic [SLOT_W-1:0]               r_slot, n_slot;

    // result payload
    logic [rpa_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [rpa_pkg::ADDR_W-1:0]      r_paddr, n_paddr;
    logic                            r_ret, n_ret;
    logic [rpa_pkg::COUNT_OUT_W-1:0] r_cnt, n_cnt;

    // ram ports
    logic                  stk_we;
    logic [SLOT_W-1:0]     stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic                  cnt_we;
    logic [SLOT_W-1:0]     cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

    // address decode
    logic [WIDE_W-1:0] pool_size, bound_diff, page_num, slot_wide;
    logic              in_pool, aligned;
    logic              accept;
    logic [COUNT_BITS-1:0] cnt_dec, cnt_inc;

    // ready while idle and in the read/modify/write state
    assign busy   = !((r_state == ST_IDLE) || (r_state == ST_RMW));
    assign accept = start && !busy;

    // pool spans [low, high), clamped to the ram depth
    always_comb begin
        bound_diff = WIDE_W'(r_high) - WIDE_W'(r_low);
        if (r_high <= r_low) begin
            pool_size = '0;
        end else if (bound_diff > WIDE_W'(NUM_PAGES)) begin
            pool_size = WIDE_W'(NUM_PAGES);
        end else begin
            pool_size = bound_diff;
        end
    end

    // page number of the held address and its slot within the pool
    assign page_num  = WIDE_W'(r_address) >> PAGE_SHIFT;
    assign slot_wide = page_num - WIDE_W'(r_low);
    assign in_pool   = (page_num >= WIDE_W'(r_low)) && (slot_wide < pool_size);
    assign aligned   = (r_address[PAGE_SHIFT-1:0] == '0);

    assign cnt_dec = cnt_rdata - COUNT_ONE;
    assign cnt_inc = cnt_rdata + COUNT_ONE;

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_sweep      = r_sweep;
        n_sweep_init = r_sweep_init;
        n_cmd        = r_cmd;
        n_address    = r_address;
        n_slot       = r_slot;
        n_valid      = 1'b0;
        n_status     = rpa_pkg::STAT_OK;
        n_paddr      = '0;
        n_ret        = 1'b0;
        n_cnt        = '0;

        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_raddr = '0;
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_raddr = '0;

        case (r_state)
            ST_IDLE: begin
                // nothing to do until a command arrives
            end

            ST_ISSUE: begin
                case (r_cmd)
                    rpa_pkg::CMD_ALLOC: begin
                        if (r_depth == '0) begin
                            n_valid  = 1'b1;
                            n_status = rpa_pkg::STAT_EMPTY;
                            n_state  = ST_IDLE;
                        end else begin
                            // pop: read the top entry, depth drops now
                            stk_raddr = SLOT_W'(r_depth - DEPTH_W'(1));
                            n_depth   = r_depth - DEPTH_W'(1);
                            n_state   = ST_RMW;
                        end
                    end
                    rpa_pkg::CMD_FREE, rpa_pkg::CMD_INCREF: begin
                        // free needs an aligned address, incref ignores the offset
                        if (!in_pool || ((r_cmd == rpa_pkg::CMD_FREE) && !aligned)) begin
                            n_valid  = 1'b1;
                            n_status = rpa_pkg::STAT_BAD;
                            n_state  = ST_IDLE;
                        end else begin
                            cnt_raddr = SLOT_W'(slot_wide);
                            n_slot    = SLOT_W'(slot_wide);
                            n_state   = ST_RMW;
                        end
                    end
                    rpa_pkg::CMD_INIT: begin
                        // stack gets slots 0..size-1 during the sweep
                        n_depth      = DEPTH_W'(pool_size);
                        n_sweep      = '0;
                        n_sweep_init = 1'b1;
                        n_state      = ST_SWEEP;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            ST_RMW: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
                case (r_cmd)
                    rpa_pkg::CMD_ALLOC: begin
                        cnt_we    = 1'b1;
                        cnt_waddr = stk_rdata;
                        cnt_wdata = COUNT_ONE;
                        n_cnt     = rpa_pkg::COUNT_OUT_W'(COUNT_ONE);
                        n_paddr   = rpa_pkg::ADDR_W'(
                            (WIDE_W'(r_low) + WIDE_W'(stk_rdata)) << PAGE_SHIFT);
                    end
                    rpa_pkg::CMD_FREE: begin
                        if (cnt_rdata == '0) begin
                            n_status = rpa_pkg::STAT_ZERO;
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_waddr = r_slot;
                            cnt_wdata = cnt_dec;
                            n_cnt     = rpa_pkg::COUNT_OUT_W'(cnt_dec);
                            // last reference gone: push back unless the stack is full
                            if ((cnt_dec == '0) && (r_depth < DEPTH_W'(NUM_PAGES))) begin
                                stk_we    = 1'b1;
                                stk_waddr = r_depth[SLOT_W-1:0];
                                stk_wdata = r_slot;
                                n_depth   = r_depth + DEPTH_W'(1);
                                n_ret     = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // incref, saturating
                        if (cnt_rdata == COUNT_MAX) begin
                            n_status = rpa_pkg::STAT_SAT;
                            n_cnt    = rpa_pkg::COUNT_OUT_W'(cnt_rdata);
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_waddr = r_slot;
                            cnt_wdata = cnt_inc;
                            n_cnt     = rpa_pkg::COUNT_OUT_W'(cnt_inc);
                        end
                    end
                endcase
            end

            default: begin
                // sweep: one count entry per cycle, stack entries below depth
                cnt_we    = 1'b1;
                cnt_waddr = r_sweep[SLOT_W-1:0];
                cnt_wdata = '0;
                if (r_sweep < r_depth) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_sweep[SLOT_W-1:0];
                    stk_wdata = r_sweep[SLOT_W-1:0];
                end
                n_sweep = r_sweep + DEPTH_W'(1);
                if (r_sweep == DEPTH_W'(NUM_PAGES - 1)) begin
                    n_state      = ST_IDLE;
                    n_valid      = r_sweep_init;  // reset pass reports nothing
                    n_sweep_init = 1'b0;
                end
            end
        endcase

        // new word taken in idle or in the write-back cycle
        if (accept) begin
            n_cmd     = i_command;
            n_address = i_address;
            n_state   = ST_ISSUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_depth      <= '0;
            r_sweep      <= '0;
            r_sweep_init <= 1'b0;
            r_valid      <= 1'b0;
            r_low        <= rpa_pkg::LOW_PAGE_RST;
            r_high       <= rpa_pkg::HIGH_PAGE_RST;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_sweep      <= n_sweep;
            r_sweep_init <= n_sweep_init;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rpa_pkg::REG_LOW_PAGE:  r_low  <= i_cfg_data;
                    rpa_pkg::REG_HIGH_PAGE: r_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_address <= n_address;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_paddr   <= n_paddr;
        r_ret     <= n_ret;
        r_cnt     <= n_cnt;
    end

    // free stack of pool slot numbers
    rpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // reference count per pool slot
    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_page_address     = r_paddr;
    assign o_returned_to_pool = r_ret;
    assign o_count_after      = r_cnt;

endmodule

// ----- hw/rtl/rpa_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpa_checker
// port-level checks of the page allocator, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [rpa_pkg::CMD_W-1:0]       i_command,
    input logic [rpa_pkg::ADDR_W-1:0]      i_address,
    input logic                            i_cfg_we,
    input logic [rpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [rpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            o_valid,
    input logic [rpa_pkg::STATUS_W-1:0]    o_status,
    input logic [rpa_pkg::ADDR_W-1:0]      o_page_address,
    input logic                            o_returned_to_pool,
    input logic [rpa_pkg::COUNT_OUT_W-1:0] o_count_after
);

    // a taken command makes the block busy in the next cycle
    `RPA_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)

    // status codes stay within the defined set
    `RPA_ASSERT_SAME(a_status_range, i_clk, i_rst_n, o_valid,
        o_status <= rpa_pkg::STAT_SAT)

    // a failed word hands out nothing and returns nothing
    `RPA_ASSERT_SAME(a_fail_quiet, i_clk, i_rst_n,
        o_valid && (o_status != rpa_pkg::STAT_OK),
        (o_page_address == '0) && !o_returned_to_pool)

    // a page goes back to the pool only when its last reference is dropped
    `RPA_ASSERT_SAME(a_return_at_zero, i_clk, i_rst_n, o_valid && o_returned_to_pool,
        (o_count_after == '0) && (o_status == rpa_pkg::STAT_OK))

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);
